/* src/frq_pkg.sv */
// types and sizing constants for the fragment reassembly frame queue
// no dependencies; used by fragment_reassembly_frame_queue_unit
`default_nettype none

package frq_pkg;

  localparam int FrameBytes  = 640;
  localparam int QueueFrames = 12;
  localparam int RingSlots   = QueueFrames + 1;
  localparam int StoreBytes  = RingSlots * FrameBytes;

  localparam int LenW  = 10;
  localparam int SlotW = $clog2(RingSlots);
  localparam int AddrW = $clog2(StoreBytes);
  localparam int HeldW = 4;

  typedef enum logic [2:0] {
    StStored       = 3'd0,
    StBadLength    = 3'd1,
    StBadSequence  = 3'd2,
    StDone         = 3'd3,
    StDoneDropped  = 3'd4,
    StRead         = 3'd5,
    StEmpty        = 3'd6
  } status_e;

  typedef struct packed {
    logic            operation;
    logic [LenW-1:0] message_total;
    logic [LenW-1:0] fragment_offset;
    logic [LenW-1:0] fragment_length;
    logic            first_of_fragment;
    logic [7:0]      byte_value;
  } in_item_t;

  typedef struct packed {
    status_e          status;
    logic [7:0]       read_byte;
    logic             read_last;
    logic [HeldW-1:0] frames_waiting;
    logic [31:0]      dropped_total;
  } out_item_t;

endpackage

`default_nettype wire

/* src/fragment_reassembly_frame_queue_unit.sv */
// fragment reassembly into a ring of frame slots with drop-oldest overflow
// depends on frq_pkg (types, store geometry)
`default_nettype none

// Usage
//   Command channel: an item on item_i is taken at a rising edge with start high
//   and busy low. busy is held low: an item may be issued in every cycle.
//   operation 0 carries one fragment byte, operation 1 reads the next byte of
//   the oldest finished frame.
//   Result channel: exactly one result per item, shown on result_o for one
//   cycle with done_o high, in the cycle right after the item is taken (one
//   item per cycle). The receiver cannot stall; a result not taken in its
//   cycle is gone.
//   Frame bytes live in a single-port synchronous store of RingSlots slots of
//   FrameBytes bytes; each item uses that port at most once (a byte write or a
//   byte read), and the read byte comes from the store's output register in
//   the result cycle. Frame lengths sit in a small per-slot register file.
//   Reset clears the queue, the assembly state and the drop counter; store
//   contents are undefined until written, and no reachable read touches an
//   unwritten entry, so no clearing pass is needed.
module fragment_reassembly_frame_queue_unit (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               start,
  output logic                    busy,
  input  wire frq_pkg::in_item_t  item_i,
  output logic                    done_o,
  output frq_pkg::out_item_t      result_o
);

  localparam int LenW  = frq_pkg::LenW;
  localparam int SlotW = frq_pkg::SlotW;
  localparam int AddrW = frq_pkg::AddrW;
  localparam int HeldW = frq_pkg::HeldW;

  localparam logic [LenW-1:0]  FrameLen   = LenW'(frq_pkg::FrameBytes);
  localparam logic [HeldW-1:0] QueueMax   = HeldW'(frq_pkg::QueueFrames);
  localparam logic [SlotW-1:0] LastSlot   = SlotW'(frq_pkg::RingSlots - 1);

  function automatic logic [SlotW-1:0] next_slot(input logic [SlotW-1:0] s);
    next_slot = (s == LastSlot) ? '0 : s + SlotW'(1);
  endfunction

  function automatic logic [AddrW-1:0] slot_addr(input logic [SlotW-1:0] s,
                                                 input logic [LenW-1:0] pos);
    slot_addr = AddrW'(s) * AddrW'(frq_pkg::FrameBytes) + AddrW'(pos);
  endfunction

  // control state
  logic [LenW-1:0]  asm_len_q, asm_len_d;
  logic [LenW-1:0]  exp_len_q, exp_len_d;
  logic             discard_q, discard_d;
  logic [SlotW-1:0] head_q, head_d;
  logic [SlotW-1:0] asm_slot_q, asm_slot_d;
  logic [HeldW-1:0] held_q, held_d;
  logic [LenW-1:0]  rd_pos_q, rd_pos_d;
  logic [31:0]      drop_q, drop_d;

  // result register
  logic                done_q;
  logic                rd_pend_q;
  frq_pkg::out_item_t  res_q, res_d;

  // frame store and length file
  logic [7:0]       store_mem [frq_pkg::StoreBytes];
  logic [7:0]       store_rdata_q;
  logic [AddrW-1:0] store_addr;
  logic             store_we;
  logic             store_re;

  logic [LenW-1:0]  len_mem [frq_pkg::RingSlots];
  logic             len_we;
  logic [LenW-1:0]  head_len;

  logic             accept;

  // byte-take helper signals
  logic             tb_en;
  logic [LenW-1:0]  tb_asm;
  logic [LenW-1:0]  tb_exp;
  logic [LenW-1:0]  tb_inc;
  logic [LenW-1:0]  hdr_asm;
  logic [LenW-1:0]  hdr_exp;
  logic [LenW:0]    hdr_sum;
  logic             hdr_bad_len;
  logic [LenW-1:0]  rd_inc;

  assign busy     = 1'b0;
  assign accept   = start && !busy;
  assign head_len = len_mem[head_q];

  always_comb begin
    asm_len_d  = asm_len_q;
    exp_len_d  = exp_len_q;
    discard_d  = discard_q;
    head_d     = head_q;
    asm_slot_d = asm_slot_q;
    held_d     = held_q;
    rd_pos_d   = rd_pos_q;
    drop_d     = drop_q;

    store_we   = 1'b0;
    store_re   = 1'b0;
    store_addr = slot_addr(head_q, rd_pos_q);
    len_we     = 1'b0;

    res_d           = '0;
    res_d.status    = frq_pkg::StStored;

    tb_en  = 1'b0;
    tb_asm = asm_len_q;
    tb_exp = exp_len_q;

    // header view: an offset of zero restarts the frame
    hdr_asm     = (item_i.fragment_offset == '0) ? '0 : asm_len_q;
    hdr_exp     = (item_i.fragment_offset == '0) ? item_i.message_total : exp_len_q;
    hdr_sum     = {1'b0, hdr_asm} + {1'b0, item_i.fragment_length};
    hdr_bad_len = (item_i.fragment_length == '0) || (item_i.message_total == '0) ||
                  (item_i.message_total > FrameLen) || item_i.message_total[0];

    rd_inc = rd_pos_q + LenW'(1);
    tb_inc = '0;

    if (item_i.operation) begin
      if (held_q == '0) begin
        res_d.status = frq_pkg::StEmpty;
      end else begin
        res_d.status = frq_pkg::StRead;
        store_re     = (rd_pos_q < FrameLen);
        store_addr   = slot_addr(head_q, rd_pos_q);
        rd_pos_d     = rd_inc;
        if (rd_inc >= head_len) begin
          res_d.read_last = 1'b1;
          rd_pos_d        = '0;
          head_d          = next_slot(head_q);
          held_d          = held_q - HeldW'(1);
        end
      end
    end else if (item_i.first_of_fragment) begin
      if (hdr_bad_len) begin
        exp_len_d    = '0;
        discard_d    = 1'b1;
        res_d.status = frq_pkg::StBadLength;
      end else begin
        asm_len_d = hdr_asm;
        exp_len_d = hdr_exp;
        if ((hdr_exp == '0) || (item_i.fragment_offset != hdr_asm) ||
            (hdr_sum > {1'b0, hdr_exp})) begin
          exp_len_d    = '0;
          discard_d    = 1'b1;
          res_d.status = frq_pkg::StBadSequence;
        end else begin
          discard_d = 1'b0;
          tb_en     = 1'b1;
          tb_asm    = hdr_asm;
          tb_exp    = hdr_exp;
        end
      end
    end else if (discard_q || (exp_len_q == '0)) begin
      res_d.status = frq_pkg::StBadSequence;
    end else begin
      tb_en = 1'b1;
    end

    if (tb_en) begin
      tb_inc       = tb_asm + LenW'(1);
      store_we     = (tb_asm < FrameLen);
      store_addr   = slot_addr(asm_slot_q, tb_asm);
      asm_len_d    = tb_inc;
      res_d.status = frq_pkg::StStored;
      if (tb_inc >= tb_exp) begin
        len_we    = 1'b1;
        exp_len_d = '0;
        if (held_q < QueueMax) begin
          held_d       = held_q + HeldW'(1);
          res_d.status = frq_pkg::StDone;
        end else begin
          head_d       = next_slot(head_q);
          rd_pos_d     = '0;
          drop_d       = drop_q + 32'd1;
          res_d.status = frq_pkg::StDoneDropped;
        end
        asm_slot_d = next_slot(asm_slot_q);
      end
    end

    res_d.frames_waiting = held_d;
    res_d.dropped_total  = drop_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      asm_len_q  <= '0;
      exp_len_q  <= '0;
      discard_q  <= 1'b0;
      head_q     <= '0;
      asm_slot_q <= '0;
      held_q     <= '0;
      rd_pos_q   <= '0;
      drop_q     <= '0;
      done_q     <= 1'b0;
      rd_pend_q  <= 1'b0;
    end else begin
      done_q    <= accept;
      rd_pend_q <= accept && store_re;
      if (accept) begin
        asm_len_q  <= asm_len_d;
        exp_len_q  <= exp_len_d;
        discard_q  <= discard_d;
        head_q     <= head_d;
        asm_slot_q <= asm_slot_d;
        held_q     <= held_d;
        rd_pos_q   <= rd_pos_d;
        drop_q     <= drop_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      res_q <= res_d;
    end
  end

  // single-port store: one byte write or one registered byte read per transfer
  always_ff @(posedge clk_i) begin
    if (accept && store_we) begin
      store_mem[store_addr] <= item_i.byte_value;
    end
    if (accept && store_re) begin
      store_rdata_q <= store_mem[store_addr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept && len_we) begin
      len_mem[asm_slot_q] <= tb_inc;
    end
  end

  always_comb begin
    result_o           = res_q;
    result_o.read_byte = rd_pend_q ? store_rdata_q : 8'd0;
  end

  assign done_o = done_q;

  // assertions
  a_held_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    held_q <= QueueMax)
    else $error("frame count above queue depth");

  a_slots_in_ring: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (head_q <= LastSlot) && (asm_slot_q <= LastSlot))
    else $error("ring slot index out of range");

  a_read_pending: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rd_pend_q |-> (done_q && (res_q.status == frq_pkg::StRead)))
    else $error("store read without a read result");

  a_drop_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_q && (res_q.status == frq_pkg::StDoneDropped)) |->
      (drop_q == $past(drop_q) + 32'd1))
    else $error("drop counter out of step with drop result");

endmodule

`default_nettype wire
